@@ rtl/wvam_pkg.sv @@
// Shared constants, types and functions for the wheel velocity and acceleration magnitude block.
`default_nettype none
package wvam_pkg;

    localparam int ANGLE_ITERATIONS = 16;

    localparam int IN_W    = 16;
    localparam int SPEED_W = 20;
    localparam int COMP_W  = 21;
    localparam int MAG_W   = 16;
    localparam int ANGLE_W = 34;
    localparam int DATA_W  = 80;

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;
    localparam logic signed [ANGLE_W-1:0] PI_Q29      = 34'sd1686629713;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q29 = 34'sd843314857;
    localparam logic signed [ANGLE_W-1:0] GAIN_Q30    = 34'sd652032874;

    localparam int DIV_STEPS  = SPEED_W + 1;
    localparam int DIV_LAT    = DIV_STEPS + 4;
    localparam int COR_LAT    = ANGLE_ITERATIONS + 1;
    localparam int SQRT_STEPS = 16;
    localparam int SQRT_LAT   = SQRT_STEPS + 3;
    localparam int ALIGN_ST   = DIV_LAT + 1;
    localparam int PIPE_DEPTH = ALIGN_ST + 2;
    localparam int COR_DLY    = ALIGN_ST - COR_LAT;
    localparam int MAG_DLY    = PIPE_DEPTH - 1 - SQRT_LAT;

    typedef enum logic [0:0] {
        REG_GEAR_RATIO   = 1'b0,
        REG_WHEEL_RADIUS = 1'b1
    } cfg_reg_t;

    function automatic logic [ANGLE_W-1:0] atan_q29(input int i);
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic        odd;
        pos = 64'd0;
        neg = 64'd0;
        odd = 1'b0;
        if (i == 0) begin
            return 34'd421657428;
        end
        for (int n = 1; n * i <= 62; n += 2) begin
            term = (64'd1 << (62 - n * i)) / 64'(n);
            if (!odd) begin
                pos = pos + term;
            end else begin
                neg = neg + term;
            end
            odd = ~odd;
        end
        return ANGLE_W'(((pos - neg) + (64'd1 << 32)) >> 33);
    endfunction

endpackage
`default_nettype wire

@@ rtl/wvam_div.sv @@
// Ground speed pipeline: product, scaling and a restoring divider, one quotient bit per stage.
`default_nettype none
module wvam_div (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [15:0]                  rpm,
    input  wire logic [15:0]                  radius,
    input  wire logic [15:0]                  gear,
    output logic [wvam_pkg::SPEED_W-1:0]      speed,
    output logic                              saturated
);

    localparam int NW = 60;
    localparam int DW = 22;
    localparam int QW = wvam_pkg::DIV_STEPS;

    logic [31:0]   p_reg;
    logic [15:0]   g1_reg;
    logic [58:0]   m_reg;
    logic [15:0]   g2_reg;
    logic          pz2_reg;
    logic [NW-1:0] n_reg;
    logic [DW-1:0] d_reg;
    logic          gz3_reg;
    logic          pz3_reg;

    logic [NW-1:0] rem_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [DW-1:0] dv_reg  [QW];
    logic          gz_reg  [QW];
    logic          pz_reg  [QW];

    logic [wvam_pkg::SPEED_W-1:0] speed_reg;
    logic                         sat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg   <= 32'(rpm) * 32'(radius);
            g1_reg  <= gear;
            m_reg   <= 59'(p_reg) * 59'(wvam_pkg::TWO_PI_Q24);
            g2_reg  <= g1_reg;
            pz2_reg <= (p_reg != 32'd0);
            n_reg   <= NW'(m_reg) + NW'({g2_reg, 24'd0}) * NW'(30);
            d_reg   <= DW'(g2_reg) * DW'(60);
            gz3_reg <= (g2_reg == 16'd0);
            pz3_reg <= pz2_reg;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_step
        localparam int K = QW - 1 - j;
        logic [NW-1:0] r_in;
        logic [QW-1:0] q_in;
        logic [DW-1:0] d_in;
        logic          gz_in;
        logic          pz_in;
        logic [66:0]   dsh;
        logic          ge;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] q_next;

        if (j == 0) begin : g_first
            assign r_in  = n_reg;
            assign q_in  = '0;
            assign d_in  = d_reg;
            assign gz_in = gz3_reg;
            assign pz_in = pz3_reg;
        end else begin : g_rest
            assign r_in  = rem_reg[j-1];
            assign q_in  = q_reg[j-1];
            assign d_in  = dv_reg[j-1];
            assign gz_in = gz_reg[j-1];
            assign pz_in = pz_reg[j-1];
        end

        assign dsh      = 67'(d_in) << (24 + K);
        assign ge       = (67'(r_in) >= dsh);
        assign rem_next = ge ? (r_in - NW'(dsh)) : r_in;
        assign q_next   = q_in | (QW'(ge) << K);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
                dv_reg[j]  <= d_in;
                gz_reg[j]  <= gz_in;
                pz_reg[j]  <= pz_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (gz_reg[QW-1]) begin
                speed_reg <= pz_reg[QW-1] ? wvam_pkg::SPEED_MAX : '0;
                sat_reg   <= pz_reg[QW-1];
            end else begin
                speed_reg <= q_reg[QW-1][QW-1] ? wvam_pkg::SPEED_MAX
                                               : q_reg[QW-1][QW-2:0];
                sat_reg   <= q_reg[QW-1][QW-1];
            end
        end
    end

    assign speed     = speed_reg;
    assign saturated = sat_reg;

endmodule
`default_nettype wire

@@ rtl/wvam_cordic.sv @@
// Rotation-mode CORDIC giving sine and cosine of the heading, one iteration per stage.
`default_nettype none
module wvam_cordic (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic signed [15:0]                   heading,
    output logic signed [wvam_pkg::ANGLE_W-1:0]       sin_q30,
    output logic signed [wvam_pkg::ANGLE_W-1:0]       cos_q30
);

    localparam int AW = wvam_pkg::ANGLE_W;
    localparam int NI = wvam_pkg::ANGLE_ITERATIONS;

    logic signed [AW-1:0] z_raw;
    logic signed [AW-1:0] zf_next;
    logic                 flip_next;
    logic signed [AW-1:0] zf_reg;
    logic                 flip_reg;

    logic signed [AW-1:0] x_reg [NI];
    logic signed [AW-1:0] y_reg [NI];
    logic signed [AW-1:0] z_reg [NI];
    logic                 f_reg [NI];

    assign z_raw = {{2{heading[15]}}, heading, 16'd0};

    always_comb begin
        zf_next   = z_raw;
        flip_next = 1'b0;
        if (z_raw > wvam_pkg::HALF_PI_Q29) begin
            zf_next   = z_raw - wvam_pkg::PI_Q29;
            flip_next = 1'b1;
        end else if (z_raw < -wvam_pkg::HALF_PI_Q29) begin
            zf_next   = z_raw + wvam_pkg::PI_Q29;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zf_reg   <= zf_next;
            flip_reg <= flip_next;
        end
    end

    for (genvar i = 0; i < NI; i++) begin : g_iter
        localparam logic signed [AW-1:0] ATAN = signed'(wvam_pkg::atan_q29(i));
        logic signed [AW-1:0] x_in;
        logic signed [AW-1:0] y_in;
        logic signed [AW-1:0] z_in;
        logic                 f_in;
        logic signed [AW-1:0] dx;
        logic signed [AW-1:0] dy;

        if (i == 0) begin : g_first
            assign x_in = wvam_pkg::GAIN_Q30;
            assign y_in = '0;
            assign z_in = zf_reg;
            assign f_in = flip_reg;
        end else begin : g_rest
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign f_in = f_reg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_in[AW-1]) begin
                    x_reg[i] <= x_in - dx;
                    y_reg[i] <= y_in + dy;
                    z_reg[i] <= z_in - ATAN;
                end else begin
                    x_reg[i] <= x_in + dx;
                    y_reg[i] <= y_in - dy;
                    z_reg[i] <= z_in + ATAN;
                end
                f_reg[i] <= f_in;
            end
        end
    end

    assign cos_q30 = f_reg[NI-1] ? -x_reg[NI-1] : x_reg[NI-1];
    assign sin_q30 = f_reg[NI-1] ? -y_reg[NI-1] : y_reg[NI-1];

endmodule
`default_nettype wire

@@ rtl/wvam_sqrt.sv @@
// Acceleration norm: squares, sum and a pipelined rounding square root, one result bit per stage.
`default_nettype none
module wvam_sqrt (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [15:0]            accel_x,
    input  wire logic signed [15:0]            accel_y,
    input  wire logic signed [15:0]            accel_z,
    output logic [wvam_pkg::MAG_W-1:0]         magnitude
);

    localparam int NS = wvam_pkg::SQRT_STEPS;

    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [30:0] sqx_reg;
    logic [30:0] sqy_reg;
    logic [30:0] sqz_reg;
    logic [31:0] sum_reg;

    logic [31:0] v_reg   [NS];
    logic [31:0] res_reg [NS];
    logic [wvam_pkg::MAG_W-1:0] mag_reg;

    assign px = 32'(accel_x) * 32'(accel_x);
    assign py = 32'(accel_y) * 32'(accel_y);
    assign pz = 32'(accel_z) * 32'(accel_z);

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= px[30:0];
            sqy_reg <= py[30:0];
            sqz_reg <= pz[30:0];
            sum_reg <= 32'(sqx_reg) + 32'(sqy_reg) + 32'(sqz_reg);
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_step
        localparam logic [31:0] BIT = 32'd1 << (30 - 2 * j);
        logic [31:0] v_in;
        logic [31:0] r_in;
        logic [32:0] trial;
        logic        ge;

        if (j == 0) begin : g_first
            assign v_in = sum_reg;
            assign r_in = '0;
        end else begin : g_rest
            assign v_in = v_reg[j-1];
            assign r_in = res_reg[j-1];
        end

        assign trial = 33'(r_in) + 33'(BIT);
        assign ge    = (33'(v_in) >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[j]   <= ge ? (v_in - trial[31:0]) : v_in;
                res_reg[j] <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= res_reg[NS-1][wvam_pkg::MAG_W-1:0]
                     + wvam_pkg::MAG_W'(v_reg[NS-1] > res_reg[NS-1]);
        end
    end

    assign magnitude = mag_reg;

endmodule
`default_nettype wire

@@ rtl/wheel_velocity_and_accel_magnitude.sv @@
// Top level: stream ports, configuration registers, alignment and component scaling.
// Each word gives one result word. The block is a fixed pipeline of 28 register stages,
// and one word is taken per cycle for as long as the output side keeps up. The depth is
// set by the speed divider (3 stages of scaling, one quotient bit per stage over 21
// stages, and a saturation stage), followed by an alignment stage, the sine/cosine
// scaling multiply and the rounding and clamping stage. The whole pipeline holds while
// m_tvalid is high and m_tready is low. Configuration writes take effect for words
// accepted afterwards.
`default_nettype none
module wheel_velocity_and_accel_magnitude (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // motor_rpm[15:0], heading[31:16], accel_x[47:32], accel_y[63:48], accel_z[79:64]
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // speed[19:0], speed_global_x[40:20], speed_global_y[61:41],
    // accel_magnitude[77:62], speed_saturated[78], zero[79]
    output logic [79:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    localparam int D  = wvam_pkg::PIPE_DEPTH;
    localparam int AW = wvam_pkg::ANGLE_W;
    localparam int SW = wvam_pkg::SPEED_W;
    localparam int CW = wvam_pkg::COMP_W;
    localparam int MW = wvam_pkg::MAG_W;
    localparam int PW = SW + 1 + AW;

    localparam logic signed [PW-1:0] RND_HALF = PW'(64'd1 << 29);
    localparam logic signed [PW-1:0] CLAMP_HI = PW'(wvam_pkg::SPEED_MAX);

    logic [15:0]  gear_reg;
    logic [15:0]  radius_reg;
    logic [D-1:0] vld_reg;
    logic         adv;

    logic [SW-1:0]        div_speed;
    logic                 div_sat;
    logic signed [AW-1:0] sin_q30;
    logic signed [AW-1:0] cos_q30;
    logic [MW-1:0]        mag;

    logic signed [AW-1:0] sd_reg [wvam_pkg::COR_DLY];
    logic signed [AW-1:0] cd_reg [wvam_pkg::COR_DLY];
    logic [MW-1:0]        md_reg [wvam_pkg::MAG_DLY];

    logic [SW-1:0]        sp26_reg;
    logic                 sat26_reg;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] py_reg;
    logic [SW-1:0]        sp27_reg;
    logic                 sat27_reg;

    logic [SW-1:0] speed_o_reg;
    logic [CW-1:0] gx_o_reg;
    logic [CW-1:0] gy_o_reg;
    logic [MW-1:0] mag_o_reg;
    logic          sat_o_reg;

    function automatic logic [CW-1:0] round_clamp(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] r;
        r = (p + RND_HALF) >>> 30;
        if (r > CLAMP_HI) begin
            return CW'(wvam_pkg::SPEED_MAX);
        end else if (r < -CLAMP_HI) begin
            return -CW'(wvam_pkg::SPEED_MAX);
        end
        return r[CW-1:0];
    endfunction

    assign adv      = !vld_reg[D-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[D-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gear_reg   <= 16'd256;
            radius_reg <= 16'd3277;
        end else if (cfg_we) begin
            unique case (wvam_pkg::cfg_reg_t'(cfg_addr))
                wvam_pkg::REG_GEAR_RATIO:   gear_reg   <= cfg_wdata;
                wvam_pkg::REG_WHEEL_RADIUS: radius_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[D-2:0], s_tvalid};
        end
    end

    wvam_div u_div (
        .aclk      (aclk),
        .en        (adv),
        .rpm       (s_tdata[15:0]),
        .radius    (radius_reg),
        .gear      (gear_reg),
        .speed     (div_speed),
        .saturated (div_sat)
    );

    wvam_cordic u_cordic (
        .aclk    (aclk),
        .en      (adv),
        .heading (s_tdata[31:16]),
        .sin_q30 (sin_q30),
        .cos_q30 (cos_q30)
    );

    wvam_sqrt u_sqrt (
        .aclk      (aclk),
        .en        (adv),
        .accel_x   (s_tdata[47:32]),
        .accel_y   (s_tdata[63:48]),
        .accel_z   (s_tdata[79:64]),
        .magnitude (mag)
    );

    for (genvar k = 0; k < wvam_pkg::COR_DLY; k++) begin : g_cdly
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (k == 0) begin
                    sd_reg[k] <= sin_q30;
                    cd_reg[k] <= cos_q30;
                end else begin
                    sd_reg[k] <= sd_reg[(k == 0) ? 0 : k-1];
                    cd_reg[k] <= cd_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    for (genvar k = 0; k < wvam_pkg::MAG_DLY; k++) begin : g_mdly
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (k == 0) begin
                    md_reg[k] <= mag;
                end else begin
                    md_reg[k] <= md_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sp26_reg    <= div_speed;
            sat26_reg   <= div_sat;
            px_reg      <= PW'(signed'({1'b0, sp26_reg}))
                         * PW'(sd_reg[wvam_pkg::COR_DLY-1]);
            py_reg      <= PW'(signed'({1'b0, sp26_reg}))
                         * PW'(cd_reg[wvam_pkg::COR_DLY-1]);
            sp27_reg    <= sp26_reg;
            sat27_reg   <= sat26_reg;
            speed_o_reg <= sp27_reg;
            sat_o_reg   <= sat27_reg;
            gx_o_reg    <= round_clamp(px_reg);
            gy_o_reg    <= round_clamp(py_reg);
            mag_o_reg   <= md_reg[wvam_pkg::MAG_DLY-1];
        end
    end

    assign m_tdata = {1'b0, sat_o_reg, mag_o_reg, gy_o_reg, gx_o_reg, speed_o_reg};

    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && sat_o_reg) |-> (speed_o_reg == wvam_pkg::SPEED_MAX))
        else $error("saturated word without full-scale speed");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> (vld_reg == '0))
        else $error("pipeline not empty after reset");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (mag_o_reg <= MW'(56756)))
        else $error("magnitude above largest possible norm");

endmodule
`default_nettype wire

@@ verif/wvam_checker.sv @@
// Checker for the wheel velocity block: predicts each result word and compares it.
`default_nettype none
module wvam_checker
    import wvam_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [79:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    output int               pending,
    output int               failures
);

    typedef struct packed {
        logic [19:0] speed;
        logic [20:0] gx;
        logic [20:0] gy;
        logic [15:0] mag;
        logic        sat;
        logic        pad;
    } odo_t;

    odo_t         odo_q[$];
    logic [15:0]  gear_sh   = 16'd256;
    logic [15:0]  radius_sh = 16'd3277;
    longint       arctan_tab[ANGLE_ITERATIONS];

    function automatic longint arctan_q29(int i);
        longint unsigned plus;
        longint unsigned minus;
        longint unsigned t;
        bit              flip;
        plus = 0;
        minus = 0;
        flip = 0;
        if (i == 0) begin
            return 64'd421657428;
        end
        for (int n = 1; n * i <= 62; n += 2) begin
            t = (64'd1 << (62 - n * i)) / longint'(n);
            if (flip) begin
                minus += t;
            end else begin
                plus += t;
            end
            flip = ~flip;
        end
        return longint'(((plus - minus) + (64'd1 << 32)) >> 33);
    endfunction

    function automatic longint unsigned root_nearest(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (v > r) r++;
        return r;
    endfunction

    function automatic longint scale_comp(longint spd, longint trig);
        longint r;
        r = (spd * trig + (64'sd1 << 29)) >>> 30;
        if (r > 1048575) r = 1048575;
        if (r < -1048575) r = -1048575;
        return r;
    endfunction

    function automatic odo_t predict_odometry(logic [79:0] w, logic [15:0] gear,
                                              logic [15:0] rad);
        odo_t            o;
        longint unsigned num;
        longint unsigned den;
        longint unsigned spd;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          ax;
        longint          ay;
        longint          az;
        bit              sat;
        bit              fold;
        sat = 0;
        fold = 0;
        num = longint'(w[15:0]) * longint'(rad) * 64'd105414357;
        if (gear == 0) begin
            spd = 0;
            if (w[15:0] != 0 && rad != 0) begin
                spd = 1048575;
                sat = 1;
            end
        end else begin
            den = 64'd60 * longint'(gear) * (64'd1 << 24);
            spd = (num + den / 2) / den;
            if (spd > 1048575) begin
                spd = 1048575;
                sat = 1;
            end
        end
        z = longint'($signed(w[31:16])) * 65536;
        if (z > 843314857) begin
            z -= 1686629713;
            fold = 1;
        end else if (z < -843314857) begin
            z += 1686629713;
            fold = 1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= arctan_tab[i];
            end else begin
                x += dx;
                y -= dy;
                z += arctan_tab[i];
            end
        end
        if (fold) begin
            x = -x;
            y = -y;
        end
        ax = $signed(w[47:32]);
        ay = $signed(w[63:48]);
        az = $signed(w[79:64]);
        o.speed = spd[19:0];
        o.gx    = 21'(scale_comp(longint'(spd), y));
        o.gy    = 21'(scale_comp(longint'(spd), x));
        o.mag   = 16'(root_nearest(ax * ax + ay * ay + az * az));
        o.sat   = sat;
        o.pad   = 1'b0;
        return o;
    endfunction

    initial begin
        failures = 0;
        pending = 0;
        for (int i = 0; i < ANGLE_ITERATIONS; i++) arctan_tab[i] = arctan_q29(i);
    end

    always @(posedge aclk) begin
        odo_t want;
        odo_t got;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_GEAR_RATIO:   gear_sh <= cfg_wdata;
                    REG_WHEEL_RADIUS: radius_sh <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                odo_q.push_back(predict_odometry(s_tdata, gear_sh, radius_sh));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[19:0], m_tdata[40:20], m_tdata[61:41], m_tdata[77:62],
                       m_tdata[78], m_tdata[79]};
                if (odo_q.size() == 0) begin
                    failures++;
                    if (failures <= 10) $display("unexpected word %h", m_tdata);
                end else begin
                    want = odo_q.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("mismatch speed %0d/%0d gx %0d/%0d gy %0d/%0d",
                                     want.speed, got.speed, $signed(want.gx),
                                     $signed(got.gx), $signed(want.gy), $signed(got.gy));
                            $display("  mag %0d/%0d sat %0d/%0d pad %0d/%0d",
                                     want.mag, got.mag, want.sat, got.sat,
                                     want.pad, got.pad);
                        end
                    end
                end
            end
            pending <= odo_q.size();
        end
    end

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Testbench top: drives samples and register writes into the block and gives the verdict.
`default_nettype none
module testbench;
    import wvam_pkg::*;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // motor_rpm[15:0], heading[31:16], accel_x[47:32], accel_y[63:48], accel_z[79:64]
    logic [79:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // speed[19:0], speed_global_x[40:20], speed_global_y[61:41],
    // accel_magnitude[77:62], speed_saturated[78], zero[79]
    logic [79:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_addr  = REG_GEAR_RATIO;
    logic [15:0] cfg_wdata = '0;
    int          pending;
    int          failures;
    bit          no_idle   = 1'b0;
    int          quiet_cnt = 0;

    localparam int QUIET_LIMIT = 4000;

    always #5 aclk = ~aclk;

    wheel_velocity_and_accel_magnitude uut (.*);

    wvam_checker chk (.*);

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    task automatic send_word(logic [15:0] rpm, logic [15:0] head,
                             logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        if (!no_idle && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax, head, rpm};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_rpm();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 200));
            1:       return 16'($urandom_range(0, 6000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_heading();
        if ($urandom_range(0, 99) < 80) return 16'($urandom_range(0, 51472) - 25736);
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_accel();
        if ($urandom_range(0, 1)) return 16'($urandom_range(0, 2048) - 1024);
        return 16'($urandom);
    endfunction

    logic [15:0] gear_set[7]   = '{16'd256, 16'd1, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0};
    logic [15:0] radius_set[7] = '{16'd3277, 16'd65535, 16'd1, 16'd3277, 16'd0,
                                   16'd0, 16'd0};

    initial begin
        logic [15:0] hd[8];
        hd = '{16'd0, 16'd25736, -16'sd25736, 16'h7fff, 16'h8000, 16'd12868,
               -16'sd12868, 16'd1};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes at reset settings, then extreme and zero register settings
        for (int i = 0; i < 8; i++) send_word(16'd3000, hd[i], 16'd256, 16'd0, 16'd0);
        send_word(16'hffff, 16'd0, 16'h8000, 16'h8000, 16'h8000);
        send_word(16'hffff, 16'd25736, 16'h7fff, 16'h7fff, 16'h7fff);
        send_word(16'd0, -16'sd25736, 16'd0, 16'd0, 16'd0);
        send_word(16'd1, 16'h8000, 16'hffff, 16'h0001, 16'h7fff);
        send_word(16'd6000, 16'd6434, 16'd300, -16'sd400, 16'd2511);
        drain();
        write_reg(REG_GEAR_RATIO, 16'd1);
        write_reg(REG_WHEEL_RADIUS, 16'd65535);
        send_word(16'hffff, 16'd100, 16'd0, 16'd0, 16'd0);
        send_word(16'd1, 16'h7fff, 16'd0, 16'd0, 16'd0);
        send_word(16'd0, 16'h8000, 16'd0, 16'd0, 16'd0);
        drain();
        write_reg(REG_GEAR_RATIO, 16'd0);
        write_reg(REG_WHEEL_RADIUS, 16'd3277);
        send_word(16'd0, 16'd200, 16'd0, 16'd0, 16'd0);
        send_word(16'd5, 16'd200, 16'd0, 16'd0, 16'd0);
        drain();
        write_reg(REG_WHEEL_RADIUS, 16'd0);
        send_word(16'd5, 16'd200, 16'd0, 16'd0, 16'd0);
        drain();

        // random phases across register settings
        for (int p = 0; p < 7; p++) begin
            if (p >= 5) begin
                gear_set[p]   = 16'($urandom_range(1, 65535));
                radius_set[p] = 16'($urandom_range(1, 65535));
            end
            write_reg(REG_GEAR_RATIO, gear_set[p]);
            write_reg(REG_WHEEL_RADIUS, radius_set[p]);
            for (int k = 0; k < 235; k++) begin
                no_idle = (p == 2);
                send_word(pick_rpm(), pick_heading(), pick_accel(), pick_accel(),
                          pick_accel());
            end
            no_idle = 1'b0;
            drain();
        end

        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
